// File: rtl/core/twc_pkg.sv
// Shared constants and control types for the two-way cache tag lookup unit.
`timescale 1ns / 1ps
`default_nettype none
package twc_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned DEF_OFFSET_BITS = 4;
  localparam int unsigned DEF_INDEX_BITS  = 6;
  localparam int unsigned DEF_ADDR_BITS   = 32;

  typedef struct packed {
    logic clr;
    logic capture;
    logic commit;
  } twc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } twc_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/two_way_cache_tag_lookup_unit.sv
// Top level of the two-way set-associative cache tag lookup unit with true LRU.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_address
//   out      output     out_valid / out_ready out_hit, out_way_used,
//                                             out_hit_count, out_miss_count
//
// Each request first does the registered read of the set RAM, then compare,
// LRU/tag write-back and result load. After reset a clearing pass writes
// every set before the first request is taken.
// The result register holds a finished request while the next one is taken;
// the write-back stalls only while that register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
module two_way_cache_tag_lookup_unit #(
  parameter int unsigned OFFSET_BITS = twc_pkg::DEF_OFFSET_BITS,
  parameter int unsigned INDEX_BITS  = twc_pkg::DEF_INDEX_BITS,
  parameter int unsigned ADDR_BITS   = twc_pkg::DEF_ADDR_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [twc_pkg::ADDR_W-1:0]  in_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_hit,
  output logic                             out_way_used,
  output logic      [twc_pkg::CNT_W-1:0]   out_hit_count,
  output logic      [twc_pkg::CNT_W-1:0]   out_miss_count
);
  import twc_pkg::*;

  twc_cmd_t cmd;
  twc_sts_t sts;

  twc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  twc_dpath #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_way_used  (out_way_used),
    .out_hit_count (out_hit_count),
    .out_miss_count(out_miss_count)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("write-back while result register occupied");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while lookup in flight");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed lookup produced no result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((out_hit_count != $past(out_hit_count)) ||
                    (out_miss_count != $past(out_miss_count)) ||
                    (out_hit_count == {CNT_W{1'b1}}) ||
                    (out_miss_count == {CNT_W{1'b1}})))
    else $error("lookup advanced neither counter");

endmodule
`default_nettype wire

// File: rtl/core/twc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module twc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/twc_ctrl.sv
// Controller state machine for the two-way cache tag lookup unit.
`timescale 1ns / 1ps
`default_nettype none
module twc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire twc_pkg::twc_sts_t sts,
  output twc_pkg::twc_cmd_t      cmd
);
  import twc_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.clr     = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/twc_dpath.sv
// Datapath: set RAM, tag compare, LRU update, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module twc_dpath #(
  parameter int unsigned OFFSET_BITS = twc_pkg::DEF_OFFSET_BITS,
  parameter int unsigned INDEX_BITS  = twc_pkg::DEF_INDEX_BITS,
  parameter int unsigned ADDR_BITS   = twc_pkg::DEF_ADDR_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire twc_pkg::twc_cmd_t           cmd,
  output twc_pkg::twc_sts_t                sts,
  input  wire logic [twc_pkg::ADDR_W-1:0]  in_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_hit,
  output logic                             out_way_used,
  output logic      [twc_pkg::CNT_W-1:0]   out_hit_count,
  output logic      [twc_pkg::CNT_W-1:0]   out_miss_count
);
  import twc_pkg::*;

  localparam int unsigned ADDR_EFF  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned TAG_SHIFT = OFFSET_BITS + INDEX_BITS;
  localparam int unsigned TAG_W     = (ADDR_EFF > TAG_SHIFT) ? (ADDR_EFF - TAG_SHIFT) : 1;
  localparam int unsigned ROW_W     = 2 * TAG_W + 3;
  localparam int unsigned NUM_SETS  = 1 << INDEX_BITS;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_EFF);

  logic [ADDR_W-1:0]     addr_masked;
  logic [ADDR_W-1:0]     tag_full;
  logic [INDEX_BITS-1:0] set_in;
  logic [TAG_W-1:0]      tag_in;

  logic [INDEX_BITS-1:0] set_r;
  logic [TAG_W-1:0]      tag_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_r;
  logic [CNT_W-1:0]      miss_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_nxt;
  logic [CNT_W-1:0]      miss_cnt_nxt;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic                  out_way_r;

  logic [ROW_W-1:0]      row_q;
  logic [ROW_W-1:0]      row_new;
  logic [ROW_W-1:0]      ram_wdata;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [TAG_W-1:0]      tag0;
  logic [TAG_W-1:0]      tag1;
  logic [TAG_W-1:0]      tag0_new;
  logic [TAG_W-1:0]      tag1_new;
  logic [1:0]            vld;
  logic [1:0]            vld_new;
  logic                  lru;
  logic                  m0;
  logic                  m1;
  logic                  hit;
  logic                  way;

  assign addr_masked = in_address & ADDR_MASK;
  assign tag_full    = addr_masked >> TAG_SHIFT;
  assign set_in      = addr_masked[TAG_SHIFT-1:OFFSET_BITS];
  assign tag_in      = tag_full[TAG_W-1:0];

  assign tag0 = row_q[TAG_W-1:0];
  assign tag1 = row_q[2*TAG_W-1:TAG_W];
  assign vld  = row_q[2*TAG_W+1:2*TAG_W];
  assign lru  = row_q[2*TAG_W+2];

  assign m0  = vld[0] && (tag0 == tag_r);
  assign m1  = vld[1] && (tag1 == tag_r);
  assign hit = m0 || m1;
  assign way = hit ? !m0 : lru;

  always_comb begin
    tag0_new = tag0;
    tag1_new = tag1;
    if (!hit && !way) begin
      tag0_new = tag_r;
    end
    if (!hit && way) begin
      tag1_new = tag_r;
    end
    vld_new    = vld | (way ? 2'b10 : 2'b01);
    row_new    = {!way, vld_new, tag1_new, tag0_new};
  end

  assign hit_cnt_nxt  = (hit && (hit_cnt_r != {CNT_W{1'b1}})) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign miss_cnt_nxt = (!hit && (miss_cnt_r != {CNT_W{1'b1}})) ? miss_cnt_r + 1'b1
                                                                 : miss_cnt_r;

  assign ram_waddr = cmd.clr ? clr_cnt_r : set_r;
  assign ram_wdata = cmd.clr ? {1'b1, 2'b00, {(2*TAG_W){1'b0}}} : row_new;

  twc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_set_ram (
    .clk  (clk),
    .we   (cmd.clr || cmd.commit),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.capture),
    .raddr(set_in),
    .rdata(row_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r <= set_in;
      tag_r <= tag_in;
    end
    if (cmd.commit) begin
      out_hit_r <= hit;
      out_way_r <= way;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == {INDEX_BITS{1'b1}});
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_hit_count  = hit_cnt_r;
  assign out_miss_count = miss_cnt_r;

endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the two-way cache tag lookup unit: directed table plus random.
`timescale 1ns / 1ps
module tb;
  import twc_pkg::*;

  localparam int unsigned OFF_W   = DEF_OFFSET_BITS;
  localparam int unsigned IDX_W   = DEF_INDEX_BITS;
  localparam int unsigned TAG_W   = DEF_ADDR_BITS - OFF_W - IDX_W;
  localparam int unsigned N_SETS  = 1 << IDX_W;
  localparam logic        WAY0    = 1'b0;
  localparam logic        WAY1    = 1'b1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          LONG_HOLD    = 80;
  localparam int          DIR_N        = 20;

  typedef struct packed {
    logic             hit;
    logic             way;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } lookup_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              known;
    lookup_result_t    want;
  } lookup_row_t;

  localparam lookup_row_t LOOKUP_TAB [DIR_N] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, WAY1, 32'd0, 32'd1}},
    '{32'h0000_000F, 1'b1, '{1'b1, WAY1, 32'd1, 32'd1}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, WAY1, 32'd1, 32'd2}},
    '{32'h0000_03F0, 1'b1, '{1'b0, WAY0, 32'd1, 32'd3}},
    '{32'hFFFF_FFF0, 1'b1, '{1'b1, WAY1, 32'd2, 32'd3}},
    '{32'h0000_03F5, 1'b1, '{1'b1, WAY0, 32'd3, 32'd3}},
    '{32'h1234_5BF0, 1'b1, '{1'b0, WAY1, 32'd3, 32'd4}},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h0000_03F0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h8000_0008, 1'b0, '0},
    '{32'h0000_0010, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAA0, 1'b0, '0},
    '{32'h0000_0400, 1'b0, '0},
    '{32'h0000_0400, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_ready;
  logic              out_hit;
  logic              out_way_used;
  logic [CNT_W-1:0]  out_hit_count;
  logic [CNT_W-1:0]  out_miss_count;

  logic [TAG_W-1:0]  model_tag0 [N_SETS];
  logic [TAG_W-1:0]  model_tag1 [N_SETS];
  logic [1:0]        model_valid [N_SETS];
  logic              model_lru [N_SETS];
  logic [CNT_W-1:0]  model_hits;
  logic [CNT_W-1:0]  model_misses;

  lookup_result_t    pending_lookups [$];
  logic [ADDR_W-1:0] recent_addr [8];
  logic [TAG_W-1:0]  hot_tag [4];
  logic [IDX_W-1:0]  hot_set [6];
  int                recent_wr;
  int                err_count;
  int                idle_pct;
  int                stall_pct;
  int                hold_req;
  int                hold_left;
  int                cycles;

  two_way_cache_tag_lookup_unit #(
    .OFFSET_BITS(DEF_OFFSET_BITS),
    .INDEX_BITS (DEF_INDEX_BITS),
    .ADDR_BITS  (DEF_ADDR_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_way_used  (out_way_used),
    .out_hit_count (out_hit_count),
    .out_miss_count(out_miss_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  function automatic lookup_result_t lookup_tags(input logic [ADDR_W-1:0] addr);
    logic [IDX_W-1:0] set_i;
    logic [TAG_W-1:0] tag_v;
    logic             m0;
    logic             m1;
    lookup_result_t   r;
    set_i = addr[OFF_W +: IDX_W];
    tag_v = addr[OFF_W + IDX_W +: TAG_W];
    m0 = model_valid[set_i][0] && (model_tag0[set_i] == tag_v);
    m1 = model_valid[set_i][1] && (model_tag1[set_i] == tag_v);
    if (m0 || m1) begin
      r.hit = 1'b1;
      r.way = m0 ? WAY0 : WAY1;
      model_hits = bump_count(model_hits);
    end else begin
      r.hit = 1'b0;
      r.way = model_lru[set_i];
      if (r.way == WAY0) begin
        model_tag0[set_i] = tag_v;
      end else begin
        model_tag1[set_i] = tag_v;
      end
      model_valid[set_i][r.way] = 1'b1;
      model_misses = bump_count(model_misses);
    end
    model_lru[set_i] = ~r.way;
    r.hits   = model_hits;
    r.misses = model_misses;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int                mode;
    logic [ADDR_W-1:0] a;
    mode = $urandom_range(99);
    a = $urandom;
    if (mode < 35) begin
      a = recent_addr[$urandom_range(7)];
      a[OFF_W-1:0] = OFF_W'($urandom);
    end else if (mode < 82) begin
      a[OFF_W +: IDX_W] = hot_set[$urandom_range(5)];
      a[OFF_W + IDX_W +: TAG_W] = hot_tag[$urandom_range(3)];
    end
    return a;
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] addr, input logic known,
                              input lookup_result_t want);
    lookup_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = lookup_tags(addr);
    pending_lookups.push_back(known ? want : r);
    recent_addr[recent_wr] = addr;
    recent_wr = (recent_wr + 1) % 8;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int n, input int idle, input int stall, input int hold_at);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = LONG_HOLD;
      send_request(pick_address(), 1'b0, '0);
    end
    pause_until_drained();
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t w;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_lookups.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result hit=%b way=%b hits=%h misses=%h", $realtime,
                 out_hit, out_way_used, out_hit_count, out_miss_count);
      end else begin
        w = pending_lookups.pop_front();
        if (out_hit !== w.hit) begin
          err_count++;
          $display("%0t: hit expected %b actual %b", $realtime, w.hit, out_hit);
        end
        if (out_way_used !== w.way) begin
          err_count++;
          $display("%0t: way_used expected %b actual %b", $realtime, w.way, out_way_used);
        end
        if (out_hit_count !== w.hits) begin
          err_count++;
          $display("%0t: hit_count expected %h actual %h", $realtime, w.hits, out_hit_count);
        end
        if (out_miss_count !== w.misses) begin
          err_count++;
          $display("%0t: miss_count expected %h actual %h", $realtime, w.misses,
                   out_miss_count);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_address = '0;
    out_ready  = 1'b0;
    err_count  = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 0;
    hold_left  = 0;
    recent_wr  = 0;
    model_hits   = '0;
    model_misses = '0;
    for (int s = 0; s < N_SETS; s++) begin
      model_tag0[s]  = '0;
      model_tag1[s]  = '0;
      model_valid[s] = 2'b00;
      model_lru[s]   = WAY1;
    end
    for (int k = 0; k < 8; k++) recent_addr[k] = $urandom;
    for (int k = 0; k < 4; k++) hot_tag[k] = TAG_W'($urandom);
    for (int k = 0; k < 6; k++) hot_set[k] = IDX_W'($urandom);
    hot_set[0] = '0;
    hot_set[1] = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_request(LOOKUP_TAB[i].addr, LOOKUP_TAB[i].known, LOOKUP_TAB[i].want);
    end
    pause_until_drained();

    run_random(300, 0, 0, -1);
    run_random(250, 59, 0, -1);
    run_random(250, 0, 59, 10);
    run_random(250, 11, 11, -1);
    run_random(100, 0, 0, 40);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_lookups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/twc_pkg.sv
rtl/core/twc_ram.sv
rtl/core/twc_ctrl.sv
rtl/core/twc_dpath.sv
rtl/core/two_way_cache_tag_lookup_unit.sv
dv/tb.sv
